FILE: design/lru_page_buffer_controller_assert.svh
// Assertion macros for the LRU page buffer controller.
`ifndef LRU_PAGE_BUFFER_CONTROLLER_ASSERT_SVH
`define LRU_PAGE_BUFFER_CONTROLLER_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define LPBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpbc assertion failed");

// Check a consequence in the cycle after a trigger.
`define LPBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpbc assertion failed");

`endif

FILE: design/lpbc_pkg.sv
// Types and codes of the LRU page buffer controller.
`default_nettype none
package lpbc_pkg;

  localparam int FRAME_W = 6;
  localparam int CFG_W   = 7;

  localparam logic [1:0] FN_READ    = 2'd0;
  localparam logic [1:0] FN_WRITE   = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;
  localparam logic [1:0] FN_FLUSH   = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_HEADER      = 3'd1;
  localparam logic [2:0] ST_MISS        = 3'd2;
  localparam logic [2:0] ST_ALL_LATCHED = 3'd3;
  localparam logic [2:0] ST_BUSY        = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  tbl_id;
    logic [31:0] page_num;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               fetch;
    logic               writeback;
    logic [9:0]         wb_table;
    logic [31:0]        wb_page;
    logic [2:0]         status;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

FILE: design/lru_page_buffer_controller.sv
// LRU page buffer controller: frame lookup, fill, eviction and flush.
//
//  channel | signals                 | handshake
//  --------+-------------------------+----------------------------------
//  request | start_i, req_i, busy_o  | taken when start_i and !busy_o
//  result  | res_valid_o, res_o      | one-cycle strobe, never stalled
//  config  | cfg_we_i, cfg_wdata_i   | frames_in_use written on cfg_we_i
//
// Every lookup sweeps the filled frames through the tag and rank memories,
// one frame a cycle, while busy_o stays high. A hit that must become most
// recent, or an eviction, adds a rank sweep. A flush keeps busy_o high while
// it sweeps and emits one result per dirty frame, or a single result with no
// writeback if none is dirty. A header page is answered without a sweep.
// The last result comes in the same cycle that busy_o drops; the result
// side never stalls. Reset clears fill count and the dirty and latch bits.
`default_nettype none
module lru_page_buffer_controller #(
  parameter int NUM_FRAMES = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire lpbc_pkg::req_t               req_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [lpbc_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                              res_valid_o,
  output lpbc_pkg::res_t                    res_o
);
  import lpbc_pkg::*;

  localparam int IW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int TW = 42;
  localparam logic [CFG_W-1:0] NF_C = CFG_W'(NUM_FRAMES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_TOUCH = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CFG_W-1:0]      cfg_q;
  logic [CW-1:0]         fill_q, fill_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic [NUM_FRAMES-1:0] dirty_q, dirty_d, latch_q, latch_d;
  req_t                  req_q, req_d;
  res_t                  res_q, res_d, out_q, out_d;
  logic                  out_vld_q, out_vld_d;
  logic                  pend_q, pend_d;
  logic                  mt_vld_q, mt_vld_d, vc_vld_q, vc_vld_d;
  logic [IW-1:0]         mt_idx_q, mt_idx_d, vc_idx_q, vc_idx_d;
  logic [IW-1:0]         mt_rank_q, mt_rank_d, vc_rank_q, vc_rank_d;
  logic [TW-1:0]         vc_tag_q, vc_tag_d;
  logic [IW-1:0]         tch_idx_q, tch_idx_d, tch_rank_q, tch_rank_d;

  // Tag and recency memories
  logic [TW-1:0] tag_mem [NUM_FRAMES];
  logic [IW-1:0] rank_mem [NUM_FRAMES];
  logic [TW-1:0] tag_rd_q, tag_wdata;
  logic [IW-1:0] rank_rd_q, rank_wdata;
  logic          tag_we, rank_we;
  logic [IW-1:0] tag_waddr, rank_waddr, raddr;

  logic [CFG_W-1:0] limit;
  logic             issue, done;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    tag_rd_q  <= tag_mem[raddr];
    rank_rd_q <= rank_mem[raddr];
  end

  // Clamp the frame limit
  always_comb begin
    if (cfg_q == '0) begin
      limit = CFG_W'(1);
    end else if (cfg_q > NF_C) begin
      limit = NF_C;
    end else begin
      limit = cfg_q;
    end
  end

  assign raddr = cnt_q[IW-1:0];
  assign issue = (cnt_q < fill_q);
  assign done  = !issue && !rd_vld_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    dirty_d    = dirty_q;
    latch_d    = latch_q;
    req_d      = req_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = 1'b0;
    pend_d     = pend_q;
    mt_vld_d   = mt_vld_q;
    mt_idx_d   = mt_idx_q;
    mt_rank_d  = mt_rank_q;
    vc_vld_d   = vc_vld_q;
    vc_idx_d   = vc_idx_q;
    vc_rank_d  = vc_rank_q;
    vc_tag_d   = vc_tag_q;
    tch_idx_d  = tch_idx_q;
    tch_rank_d = tch_rank_q;
    tag_we     = 1'b0;
    tag_waddr  = mt_idx_q;
    tag_wdata  = {req_q.tbl_id, req_q.page_num};
    rank_we    = 1'b0;
    rank_waddr = rd_idx_q;
    rank_wdata = rank_rd_q;

    // Advance the sweep address
    if (state_q == S_SCAN || state_q == S_TOUCH || state_q == S_FLUSH) begin
      if (issue) begin
        cnt_d    = cnt_q + CW'(1);
        rd_vld_d = 1'b1;
        rd_idx_d = cnt_q[IW-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          cnt_d    = '0;
          mt_vld_d = 1'b0;
          vc_vld_d = 1'b0;
          pend_d   = 1'b0;
          res_d    = '0;
          res_d.last = 1'b1;
          if (req_i.func == FN_FLUSH) begin
            state_d = S_FLUSH;
          end else if (req_i.page_num == '0) begin
            res_d.status = ST_HEADER;
            state_d = S_SEND;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Track the match and the least recent unlatched frame
        if (rd_vld_q) begin
          if (!mt_vld_q && tag_rd_q == {req_q.tbl_id, req_q.page_num}) begin
            mt_vld_d  = 1'b1;
            mt_idx_d  = rd_idx_q;
            mt_rank_d = rank_rd_q;
          end
          if (!latch_q[rd_idx_q] && (!vc_vld_q || rank_rd_q < vc_rank_q)) begin
            vc_vld_d  = 1'b1;
            vc_idx_d  = rd_idx_q;
            vc_rank_d = rank_rd_q;
            vc_tag_d  = tag_rd_q;
          end
        end
        if (done) begin
          cnt_d   = '0;
          state_d = S_SEND;
          if (mt_vld_q) begin
            res_d.frame = FRAME_W'(mt_idx_q);
            res_d.hit   = 1'b1;
            tch_idx_d   = mt_idx_q;
            tch_rank_d  = mt_rank_q;
            if (req_q.func == FN_WRITE) begin
              dirty_d[mt_idx_q] = 1'b1;
              state_d = S_TOUCH;
            end else if (req_q.func == FN_RELEASE) begin
              latch_d[mt_idx_q] = 1'b0;
            end else if (latch_q[mt_idx_q]) begin
              res_d.status = ST_BUSY;
            end else begin
              latch_d[mt_idx_q] = 1'b1;
              state_d = S_TOUCH;
            end
          end else if (req_q.func != FN_READ) begin
            res_d.status = ST_MISS;
          end else if (CFG_W'(fill_q) < limit && fill_q < CW'(NUM_FRAMES)) begin
            // Fill the next free frame
            tag_we      = 1'b1;
            tag_waddr   = fill_q[IW-1:0];
            rank_we     = 1'b1;
            rank_waddr  = fill_q[IW-1:0];
            rank_wdata  = fill_q[IW-1:0];
            dirty_d[fill_q[IW-1:0]] = 1'b0;
            latch_d[fill_q[IW-1:0]] = 1'b1;
            fill_d      = fill_q + CW'(1);
            res_d.frame = FRAME_W'(fill_q[IW-1:0]);
            res_d.fetch = 1'b1;
          end else if (!vc_vld_q) begin
            res_d.status = ST_ALL_LATCHED;
          end else begin
            // Evict the victim
            tag_we      = 1'b1;
            tag_waddr   = vc_idx_q;
            res_d.frame = FRAME_W'(vc_idx_q);
            res_d.fetch = 1'b1;
            if (dirty_q[vc_idx_q]) begin
              res_d.writeback = 1'b1;
              res_d.wb_table  = vc_tag_q[TW-1:32];
              res_d.wb_page   = vc_tag_q[31:0];
            end
            dirty_d[vc_idx_q] = 1'b0;
            latch_d[vc_idx_q] = 1'b1;
            tch_idx_d  = vc_idx_q;
            tch_rank_d = vc_rank_q;
            state_d    = S_TOUCH;
          end
        end
      end

      S_TOUCH: begin
        // Move the frame to most recent, pull the newer ones down
        if (rd_vld_q) begin
          rank_we = 1'b1;
          if (rd_idx_q == tch_idx_q) begin
            rank_wdata = IW'(fill_q - CW'(1));
          end else if (rank_rd_q > tch_rank_q) begin
            rank_wdata = rank_rd_q - IW'(1);
          end
        end
        if (done) begin
          state_d = S_SEND;
        end
      end

      S_FLUSH: begin
        // Report dirty frames, one behind to mark the last
        if (rd_vld_q && dirty_q[rd_idx_q]) begin
          dirty_d[rd_idx_q] = 1'b0;
          if (pend_q) begin
            out_d      = res_q;
            out_d.last = 1'b0;
            out_vld_d  = 1'b1;
          end
          pend_d          = 1'b1;
          res_d           = '0;
          res_d.frame     = FRAME_W'(rd_idx_q);
          res_d.writeback = 1'b1;
          res_d.wb_table  = tag_rd_q[TW-1:32];
          res_d.wb_page   = tag_rd_q[31:0];
          res_d.last      = 1'b1;
        end
        if (done) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_SEND: begin
        out_d     = res_q;
        out_vld_d = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_q     <= CFG_W'(16);
      fill_q    <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      dirty_q   <= '0;
      latch_q   <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      mt_vld_q  <= 1'b0;
      vc_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      dirty_q   <= dirty_d;
      latch_q   <= latch_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
      mt_vld_q  <= mt_vld_d;
      vc_vld_q  <= vc_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    req_q      <= req_d;
    res_q      <= res_d;
    out_q      <= out_d;
    mt_idx_q   <= mt_idx_d;
    mt_rank_q  <= mt_rank_d;
    vc_idx_q   <= vc_idx_d;
    vc_rank_q  <= vc_rank_d;
    vc_tag_q   <= vc_tag_d;
    tch_idx_q  <= tch_idx_d;
    tch_rank_q <= tch_rank_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

`include "lru_page_buffer_controller_assert.svh"

  `LPBC_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `LPBC_ASSERT_IMP(a_hit_no_fetch, res_valid_o && res_o.hit, !res_o.fetch)
  `LPBC_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CW'(NUM_FRAMES))
  `LPBC_ASSERT_IMP(a_wb_ok, res_valid_o && res_o.writeback, !res_o.hit && res_o.status == ST_OK)

endmodule
`default_nettype wire
